>>> sv/frl_pkg.sv
// frl_pkg: shared types, constants and helpers for the fault record ring log
// used by frl_in_stage, frl_slot_track and fault_record_ring_log
package frl_pkg;

   localparam logic       ACTION_LOG   = 1'b0;
   localparam logic       ACTION_CLEAR = 1'b1;
   localparam logic [7:0] ERASED_BYTE  = 8'hFF;
   localparam logic [7:0] EMPTY_CODE   = 8'h00;
   localparam logic [4:0] COUNT_MAX    = 5'd31;

   typedef struct packed {
      logic        action;
      logic [7:0]  fault_code;
      logic [7:0]  severity;
      logic [15:0] timestamp;
      logic [7:0]  detail_a;
      logic [7:0]  detail_b;
   } frl_item_type;

   typedef struct packed {
      logic [4:0] count;
      logic [3:0] slot;
   } frl_status_type;

   function automatic logic code_is_valid(input logic [7:0] code);
      return (code != EMPTY_CODE) && (code != ERASED_BYTE);
   endfunction

endpackage

>>> sv/fault_record_ring_log.sv
// fault_record_ring_log: top level, builds records and holds the result register
// depends on frl_pkg, frl_in_stage and frl_slot_track
//
// One request word is taken per cycle: it is held in the input register,
// then the record, checksum and slot count are worked out and land in the
// result register, which drives the response, so requests stream back to
// back while rsp_ready stays high. The newest record reported is always the
// one just logged, or the erased pattern (all 0xFF) after a clear, so the
// record bytes never have to be read back. Valid codes are tracked by one
// flag per slot and a running count; a clear resets them together, there is
// no clearing pass after reset.
module fault_record_ring_log
   import frl_pkg::*;
#(
   parameter int LOG_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_fault_code,
   input  logic [7:0]  req_severity,
   input  logic [15:0] req_timestamp,
   input  logic [7:0]  req_detail_a,
   input  logic [7:0]  req_detail_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_newest_code,
   output logic [7:0]  rsp_newest_severity,
   output logic [15:0] rsp_newest_timestamp,
   output logic [7:0]  rsp_newest_detail_a,
   output logic [7:0]  rsp_newest_detail_b,
   output logic [7:0]  rsp_newest_cause,
   output logic [7:0]  rsp_newest_check,
   output logic [4:0]  rsp_valid_count,
   output logic [3:0]  rsp_next_slot
);

   logic [7:0]     cause_ff;
   frl_item_type   req_item;
   frl_item_type   cur_item;
   logic           cur_valid;
   logic           advance;
   frl_status_type status_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     code_ff, severity_ff, detail_a_ff, detail_b_ff, rcause_ff, check_ff;
   logic [15:0]    timestamp_ff;
   logic [4:0]     count_ff;
   logic [3:0]     slot_ff;
   logic [7:0]     check_in;

   assign req_item = '{action:     req_action,
                       fault_code: req_fault_code,
                       severity:   req_severity,
                       timestamp:  req_timestamp,
                       detail_a:   req_detail_a,
                       detail_b:   req_detail_b};

   assign advance = cur_valid && (!rsp_valid_ff || rsp_ready);

   frl_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (cur_valid),
      .out_take  (advance),
      .out_item  (cur_item)
   );

   frl_slot_track #(
      .LOG_SLOTS (LOG_SLOTS)
   ) u_slot_track (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .action     (cur_item.action),
      .fault_code (cur_item.fault_code),
      .status_in  (status_in)
   );

   // xor of the seven record bytes
   assign check_in = cur_item.fault_code ^ cur_item.severity ^ cur_item.timestamp[15:8]
                   ^ cur_item.timestamp[7:0] ^ cur_item.detail_a ^ cur_item.detail_b
                   ^ cause_ff;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cause_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            cause_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         count_ff <= status_in.count;
         slot_ff  <= status_in.slot;
         if (cur_item.action == ACTION_CLEAR) begin
            // newest slot is erased after a clear
            code_ff      <= ERASED_BYTE;
            severity_ff  <= ERASED_BYTE;
            timestamp_ff <= {ERASED_BYTE, ERASED_BYTE};
            detail_a_ff  <= ERASED_BYTE;
            detail_b_ff  <= ERASED_BYTE;
            rcause_ff    <= ERASED_BYTE;
            check_ff     <= ERASED_BYTE;
         end else begin
            code_ff      <= cur_item.fault_code;
            severity_ff  <= cur_item.severity;
            timestamp_ff <= cur_item.timestamp;
            detail_a_ff  <= cur_item.detail_a;
            detail_b_ff  <= cur_item.detail_b;
            rcause_ff    <= cause_ff;
            check_ff     <= check_in;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_newest_code      = code_ff;
   assign rsp_newest_severity  = severity_ff;
   assign rsp_newest_timestamp = timestamp_ff;
   assign rsp_newest_detail_a  = detail_a_ff;
   assign rsp_newest_detail_b  = detail_b_ff;
   assign rsp_newest_cause     = rcause_ff;
   assign rsp_newest_check     = check_ff;
   assign rsp_valid_count      = count_ff;
   assign rsp_next_slot        = slot_ff;

endmodule

>>> sv/frl_in_stage.sv
// frl_in_stage: input register of the ring log, holds one request word
// depends on frl_pkg for the item type
module frl_in_stage
   import frl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  frl_item_type in_item,
   output logic         out_valid,
   input  logic         out_take,
   output frl_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   frl_item_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

>>> sv/frl_slot_track.sv
// frl_slot_track: write slot, per-slot code flags and live record count
// depends on frl_pkg for the status type and code check
module frl_slot_track
   import frl_pkg::*;
#(
   parameter int LOG_SLOTS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           action,
   input  logic [7:0]     fault_code,
   output frl_status_type status_in
);

   localparam int SLOT_W = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
   localparam int CNT_W  = $clog2(LOG_SLOTS + 1);
   localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
   localparam int NS_W   = (SLOT_W > 4) ? SLOT_W : 4;

   logic [LOG_SLOTS-1:0] live_ff, live_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 new_live;
   logic                 old_live;
   logic [CMP_W-1:0]     count_wide;
   logic [NS_W-1:0]      slot_wide;

   assign new_live = code_is_valid(fault_code);
   assign old_live = live_ff[slot_ff];

   always_comb begin
      live_in  = live_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      if (action == ACTION_CLEAR) begin
         live_in  = '0;
         slot_in  = '0;
         count_in = '0;
      end else begin
         live_in[slot_ff] = new_live;
         // overwrite replaces the old record's contribution
         count_in = count_ff + CNT_W'(new_live) - CNT_W'(old_live);
         if (slot_ff == SLOT_W'(LOG_SLOTS - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   assign count_wide = CMP_W'(count_in);
   assign slot_wide  = NS_W'(slot_in);
   assign status_in.count = (count_wide > CMP_W'(COUNT_MAX)) ? COUNT_MAX : count_wide[4:0];
   assign status_in.slot  = slot_wide[3:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         slot_ff  <= '0;
         count_ff <= '0;
      end else if (step) begin
         live_ff  <= live_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> sim/frl_log_checker.sv
// frl_log_checker: watches the request, response and csr ports of the fault record ring log,
// predicts each response word from its own copy of the ring and compares field by field
// depends on frl_pkg for the request word type and the code constants
module frl_log_checker
   import frl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_fault_code,
   input  logic [7:0]  req_severity,
   input  logic [15:0] req_timestamp,
   input  logic [7:0]  req_detail_a,
   input  logic [7:0]  req_detail_b,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_newest_code,
   input  logic [7:0]  rsp_newest_severity,
   input  logic [15:0] rsp_newest_timestamp,
   input  logic [7:0]  rsp_newest_detail_a,
   input  logic [7:0]  rsp_newest_detail_b,
   input  logic [7:0]  rsp_newest_cause,
   input  logic [7:0]  rsp_newest_check,
   input  logic [4:0]  rsp_valid_count,
   input  logic [3:0]  rsp_next_slot,
   output int          mismatches,
   output int          reports_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;

   typedef struct packed {
      logic [7:0]  code;
      logic [7:0]  severity;
      logic [15:0] stamp;
      logic [7:0]  detail_a;
      logic [7:0]  detail_b;
      logic [7:0]  cause;
      logic [7:0]  check;
   } fault_record_type;

   typedef struct packed {
      fault_record_type newest;
      logic [4:0]       count;
      logic [3:0]       slot;
   } log_report_type;

   fault_record_type ring [SLOTS];
   int unsigned      head_slot;
   logic [7:0]       cause_reg;
   log_report_type   pending_reports [$];
   int               errors = 0;

   function automatic log_report_type log_or_clear(input frl_item_type w);
      fault_record_type rec;
      log_report_type   rep;
      int unsigned      live;
      if (w.action == ACTION_CLEAR) begin
         foreach (ring[s]) ring[s] = '1;
         head_slot = 0;
      end else begin
         rec.code     = w.fault_code;
         rec.severity = w.severity;
         rec.stamp    = w.timestamp;
         rec.detail_a = w.detail_a;
         rec.detail_b = w.detail_b;
         rec.cause    = cause_reg;
         rec.check    = rec.code ^ rec.severity ^ rec.stamp[15:8] ^ rec.stamp[7:0]
                        ^ rec.detail_a ^ rec.detail_b ^ rec.cause;
         ring[head_slot] = rec;
         head_slot = (head_slot + 1 == SLOTS) ? 0 : head_slot + 1;
      end
      live = 0;
      foreach (ring[s])
         if (ring[s].code != EMPTY_CODE && ring[s].code != ERASED_BYTE) live++;
      // newest record sits just behind the write slot, wrapping to the top
      rep.newest = ring[(head_slot + SLOTS - 1) % SLOTS];
      rep.count  = (live > COUNT_MAX) ? COUNT_MAX : 5'(live);
      rep.slot   = 4'(head_slot);
      return rep;
   endfunction

   function automatic void check_field(input string what, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      frl_item_type   w;
      log_report_type want;
      if (reset) begin
         foreach (ring[s]) ring[s] = '1;
         head_slot = 0;
         cause_reg = 8'h00;
         pending_reports.delete();
      end else begin
         if (csr_write) cause_reg = csr_wdata;
         if (req_valid && req_ready) begin
            w = '{action: req_action, fault_code: req_fault_code, severity: req_severity,
                  timestamp: req_timestamp, detail_a: req_detail_a, detail_b: req_detail_b};
            pending_reports.push_back(log_or_clear(w));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               errors++;
               if (errors <= 10) $display("%0t: response word with nothing outstanding", $time);
            end else begin
               want = pending_reports.pop_front();
               check_field("newest_code", want.newest.code, rsp_newest_code);
               check_field("newest_severity", want.newest.severity, rsp_newest_severity);
               check_field("newest_timestamp", want.newest.stamp, rsp_newest_timestamp);
               check_field("newest_detail_a", want.newest.detail_a, rsp_newest_detail_a);
               check_field("newest_detail_b", want.newest.detail_b, rsp_newest_detail_b);
               check_field("newest_cause", want.newest.cause, rsp_newest_cause);
               check_field("newest_check", want.newest.check, rsp_newest_check);
               check_field("valid_count", want.count, rsp_valid_count);
               check_field("next_slot", want.slot, rsp_next_slot);
            end
         end
      end
      mismatches  <= errors;
      reports_due <= pending_reports.size();
   end

endmodule

>>> sim/tb.sv
// tb: drives logs, clears and reset cause writes into fault_record_ring_log under
// varying back-pressure and gives the verdict; depends on frl_pkg and frl_log_checker
module tb
   import frl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACTION_LOG;
   logic [7:0]  req_fault_code = 8'h00;
   logic [7:0]  req_severity = 8'h00;
   logic [15:0] req_timestamp = 16'h0000;
   logic [7:0]  req_detail_a = 8'h00;
   logic [7:0]  req_detail_b = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_newest_code;
   logic [7:0]  rsp_newest_severity;
   logic [15:0] rsp_newest_timestamp;
   logic [7:0]  rsp_newest_detail_a;
   logic [7:0]  rsp_newest_detail_b;
   logic [7:0]  rsp_newest_cause;
   logic [7:0]  rsp_newest_check;
   logic [4:0]  rsp_valid_count;
   logic [3:0]  rsp_next_slot;
   int          mismatches;
   int          reports_due;
   int          send_gap_pct = 0;
   int          stall_pct = 0;

   fault_record_ring_log dut (.*);
   frl_log_checker log_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= stall_pct);

   function automatic frl_item_type log_word(input logic [7:0] code, input logic [7:0] sev,
                                             input logic [15:0] stamp, input logic [7:0] a,
                                             input logic [7:0] b);
      return '{action: ACTION_LOG, fault_code: code, severity: sev, timestamp: stamp,
               detail_a: a, detail_b: b};
   endfunction

   function automatic frl_item_type random_word();
      frl_item_type w;
      int           pick;
      w = log_word(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(3) == 0) w.severity = 8'($urandom_range(2));
      if ($urandom_range(15) == 0) w.timestamp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      pick = $urandom_range(99);
      // mostly logs so the ring fills and wraps between clears
      if (pick < 5) w.action = ACTION_CLEAR;
      else if (pick < 13) w.fault_code = $urandom_range(1) ? ERASED_BYTE : EMPTY_CODE;
      return w;
   endfunction

   task automatic send_word(input frl_item_type w);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= w.action;
      req_fault_code <= w.fault_code;
      req_severity   <= w.severity;
      req_timestamp  <= w.timestamp;
      req_detail_a   <= w.detail_a;
      req_detail_b   <= w.detail_b;
      do @(posedge clock); while (!req_ready);
   endtask

   // only written with the pipe drained
   task automatic write_cause(input logic [7:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      logic [7:0] causes [6];
      causes = '{8'h00, 8'h5A, 8'hFF, 8'h80, 8'h01, 8'h7F};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct <= 14;
      stall_pct    <= 73;

      // empty and erased codes, then two clears, the second on an already erased ring
      send_word(log_word(EMPTY_CODE, 8'h00, 16'h0000, 8'h00, 8'h00));
      send_word(log_word(ERASED_BYTE, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF));
      send_word('1);
      send_word('1);
      write_cause(8'hFF);
      // seventeen live codes: fills the ring, wraps the slot, overwrites slot zero
      for (int i = 0; i < 17; i++)
         send_word(log_word(8'(i + 1), 8'(i % 3), i[0] ? 16'hFFFF : 16'h0000,
                            8'(i * 15), 8'(255 - i * 15)));
      send_word(log_word(EMPTY_CODE, 8'h02, 16'h8001, 8'h55, 8'hAA));
      send_word(log_word(ERASED_BYTE, 8'h01, 16'h7FFE, 8'hAA, 8'h55));
      send_word('{action: ACTION_CLEAR, default: '0});

      for (int p = 0; p < 3; p++) begin
         send_gap_pct <= (p == 0) ? 14 : (p == 1) ? 73 : 0;
         stall_pct    <= (p == 0) ? 73 : (p == 1) ? 14 : 0;
         for (int s = 0; s < 2; s++) begin
            write_cause((p * 2 + s == 3) ? 8'($urandom) : causes[p * 2 + s]);
            repeat (175) send_word(random_word());
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && reports_due == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
